@@ sv/etfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ESC telemetry frame parser package
// Types and constants shared by the frame parser modules.
// ----------------------------------------------------------------------------
package etfp_pkg;

   localparam int unsigned FRAME_LENGTH = 10;
   localparam int unsigned CRC_INDEX    = FRAME_LENGTH - 1;
   localparam int unsigned INDEX_WIDTH  = 4;

   localparam logic [7:0]  CRC_POLY = 8'h07;
   localparam logic [7:0]  CRC_TOP  = 8'h80;
   localparam logic [15:0] LOST_MAX = 16'hFFFF;

   typedef struct packed {
      logic [7:0]  temperature;
      logic [15:0] voltage;
      logic [15:0] current;
      logic [15:0] consumption;
      logic [15:0] rpm;
      logic        crc_ok;
   } frame_type;

endpackage

@@ sv/esc_telemetry_frame_parser_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ESC telemetry frame parser
// Assembles ten-byte telemetry frames, checks their CRC-8 and counts losses.
//
//   Channel   Direction  Ports
//   req       in         req_push, req_full, req_data_byte
//   rsp       out        rsp_pop, rsp_empty, rsp_temperature .. rsp_lost_count
//
// One byte is taken every cycle while req_full is low; the CRC update is done
// in the cycle a byte arrives. A finished frame enters the frame queue when its
// tenth byte is accepted and is loaded into the result register once that is
// empty or popped. Reset clears the frame position, CRC, queue and lost count.
// The tenth byte of a frame is held off only while the frame queue is full.
// ----------------------------------------------------------------------------
module esc_telemetry_frame_parser_core #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [7:0]  rsp_temperature,
   output logic [15:0] rsp_voltage,
   output logic [15:0] rsp_current,
   output logic [15:0] rsp_consumption,
   output logic [15:0] rsp_rpm,
   output logic        rsp_crc_ok,
   output logic [15:0] rsp_lost_count
);

   etfp_pkg::frame_type front_frame;
   etfp_pkg::frame_type queue_frame;
   etfp_pkg::frame_type result;
   logic                frame_push;
   logic                queue_full;
   logic                queue_empty;
   logic                queue_pop;

   etfp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .data_byte  (req_data_byte),
      .full       (req_full),
      .frame_push (frame_push),
      .frame      (front_frame),
      .queue_full (queue_full)
   );

   etfp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (frame_push),
      .push_frame (front_frame),
      .full       (queue_full),
      .pop        (queue_pop),
      .pop_frame  (queue_frame),
      .empty      (queue_empty)
   );

   etfp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_frame (queue_frame),
      .queue_pop   (queue_pop),
      .empty       (rsp_empty),
      .pop         (rsp_pop),
      .result      (result),
      .lost_count  (rsp_lost_count)
   );

   assign rsp_temperature = result.temperature;
   assign rsp_voltage     = result.voltage;
   assign rsp_current     = result.current;
   assign rsp_consumption = result.consumption;
   assign rsp_rpm         = result.rpm;
   assign rsp_crc_ok      = result.crc_ok;

endmodule

@@ sv/etfp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ESC telemetry frame assembler
// Collects bytes, runs the CRC-8 and emits one decoded frame per ten bytes.
// ----------------------------------------------------------------------------
module etfp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [7:0]          data_byte,
   output logic                full,
   output logic                frame_push,
   output etfp_pkg::frame_type frame,
   input  logic                queue_full
);

   localparam int unsigned NUM_BYTES = etfp_pkg::FRAME_LENGTH - 1;

   logic [etfp_pkg::INDEX_WIDTH-1:0] index_ff;
   logic [etfp_pkg::INDEX_WIDTH-1:0] index_in;
   logic [7:0]                       crc_ff;
   logic [7:0]                       crc_in;
   logic [7:0]                       bytes_ff [NUM_BYTES];
   logic                             at_crc;
   logic                             accept;

   function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] value);
      logic [7:0] v;
      v = crc ^ value;
      for (int k = 0; k < 8; k++) begin
         if ((v & etfp_pkg::CRC_TOP) != 8'h00) begin
            v = {v[6:0], 1'b0} ^ etfp_pkg::CRC_POLY;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      return v;
   endfunction

   assign at_crc     = (index_ff >= etfp_pkg::INDEX_WIDTH'(etfp_pkg::CRC_INDEX));
   assign full       = at_crc && queue_full;
   assign accept     = push && !full;
   assign frame_push = accept && at_crc;

   always_comb begin
      frame.temperature = bytes_ff[0];
      frame.voltage     = {bytes_ff[1], bytes_ff[2]};
      frame.current     = {bytes_ff[3], bytes_ff[4]};
      frame.consumption = {bytes_ff[5], bytes_ff[6]};
      frame.rpm         = {bytes_ff[7], bytes_ff[8]};
      frame.crc_ok      = (data_byte == crc_ff);
   end

   always_comb begin
      index_in = index_ff;
      crc_in   = crc_ff;
      if (accept) begin
         if (at_crc) begin
            index_in = '0;
            crc_in   = '0;
         end else begin
            index_in = index_ff + 1'b1;
            crc_in   = crc_feed(crc_ff, data_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         crc_ff   <= '0;
      end else begin
         index_ff <= index_in;
         crc_ff   <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_BYTES; i++) begin
         if (accept && !at_crc && (index_ff == etfp_pkg::INDEX_WIDTH'(i))) begin
            bytes_ff[i] <= data_byte;
         end
      end
   end

endmodule

@@ sv/etfp_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ESC telemetry frame queue
// Short FIFO of decoded frames between the assembler and the result stage.
// ----------------------------------------------------------------------------
module etfp_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  etfp_pkg::frame_type push_frame,
   output logic                full,
   input  logic                pop,
   output etfp_pkg::frame_type pop_frame,
   output logic                empty
);

   localparam int unsigned PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_WIDTH = $clog2(DEPTH + 1);

   etfp_pkg::frame_type  mem_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff;
   logic [PTR_WIDTH-1:0] wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff;
   logic [PTR_WIDTH-1:0] rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff;
   logic [CNT_WIDTH-1:0] count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full      = (count_ff == CNT_WIDTH'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign pop_frame = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

@@ sv/etfp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ESC telemetry result stage
// Counts lost frames and holds the result register that the consumer reads.
// ----------------------------------------------------------------------------
module etfp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_empty,
   input  etfp_pkg::frame_type queue_frame,
   output logic                queue_pop,
   output logic                empty,
   input  logic                pop,
   output etfp_pkg::frame_type result,
   output logic [15:0]         lost_count
);

   logic                valid_ff;
   logic                valid_in;
   etfp_pkg::frame_type result_ff;
   logic [15:0]         lost_ff;
   logic [15:0]         lost_in;
   logic                load;

   assign load      = !queue_empty && (!valid_ff || pop);
   assign queue_pop = load;
   assign empty     = !valid_ff;
   assign result    = result_ff;
   assign lost_count = lost_ff;

   always_comb begin
      valid_in = valid_ff;
      lost_in  = lost_ff;
      if (load) begin
         valid_in = 1'b1;
         if (!queue_frame.crc_ok && (lost_ff != etfp_pkg::LOST_MAX)) begin
            lost_in = lost_ff + 16'd1;
         end
      end else if (pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         lost_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         lost_ff  <= lost_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= queue_frame;
      end
   end

endmodule
